@@ src/spr_pkg.sv @@
// spr_pkg: shared types and constants for the split packet reassembler
// used by split_packet_reassembler and spr_store
`default_nettype none

package spr_pkg;

    localparam int unsigned CFG_INDEX_W = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_BYTE     = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHECKSUM_SEED = 8'd1;

    localparam logic [7:0] SYNC_BYTE_RESET     = 8'hD1;
    localparam logic [7:0] CHECKSUM_SEED_RESET = 8'h40;

    typedef enum logic [2:0] {
        MODE_SEARCH   = 3'b001,
        MODE_FULL     = 3'b010,
        MODE_COMPLETE = 3'b100
    } chunk_mode_t;

    typedef struct packed {
        logic stream;
        logic fail;
    } store_cmd_t;

    typedef struct packed {
        logic busy;
        logic full;
    } store_status_t;

endpackage

`default_nettype wire

@@ src/split_packet_reassembler.sv @@
// split_packet_reassembler: top level, chunk tracking, resync and checksum
// depends on spr_pkg and spr_store
//
// Bytes enter on data_byte (in_valid / in_stall); every PACKET_BYTES accepted
// bytes form one chunk, aligned from reset. A chunk starting with the sync
// byte is a full packet; otherwise its head may complete a partial packet
// kept from an earlier chunk, or the chunk is searched for a sync byte whose
// tail is kept as a new partial packet. The checksum is accumulated while
// the bytes arrive, so no pass over the memory is needed at the chunk end.
// Results leave on out_byte / packet_ok / last (out_valid / out_stall).
// A good packet streams all PACKET_BYTES bytes from the packet memory, one
// per cycle while out_stall is low, after the last byte of the chunk; any
// other chunk end gives one item with packet_ok low. Chunk bytes are taken
// one per cycle; while a packet streams, input is held off until the last
// packet byte reaches the output register.
// The last byte of a chunk is also held while the output register is full.
// Registers sync_byte (index 0) and checksum_seed (index 1) are written on
// the cfg channel, ready always high. Reset clears the chunk position, the
// partial packet and the output, and restores the register defaults.
`default_nettype none

module split_packet_reassembler #(
    parameter int unsigned PACKET_BYTES = 29
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [7:0]                       data_byte,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [7:0]                            out_byte,
    output logic                                  packet_ok,
    output logic                                  last,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [spr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [7:0]                       cfg_data
);

    localparam int unsigned POS_W = $clog2(PACKET_BYTES);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(PACKET_BYTES - 1);

    logic [7:0] sync_reg, seed_reg;

    logic [POS_W-1:0]     pos_reg, pos_next;
    spr_pkg::chunk_mode_t mode_reg, mode_next;
    logic                 found_reg, found_next;
    logic [POS_W-1:0]     offset_reg, offset_next;
    logic                 awaiting_reg, awaiting_next;
    logic [POS_W-1:0]     missing_reg, missing_next;
    logic [7:0]           acc_reg, acc_next;
    logic [7:0]           tail_reg, tail_next;
    logic [7:0]           prefix_reg, prefix_next;

    spr_pkg::chunk_mode_t  cur_mode;
    spr_pkg::store_cmd_t   cmd;
    spr_pkg::store_status_t status;

    logic             take;
    logic             is_end;
    logic             wr_en;
    logic [POS_W-1:0] wr_addr;
    logic [POS_W-1:0] missing_m1;
    logic [7:0]       base;
    logic             hit;
    logic             keep;
    logic             pass;

    assign cfg_ready  = 1'b1;
    assign in_stall   = status.busy || ((pos_reg == LAST_POS) && status.full);
    assign take       = in_valid && !in_stall;
    assign is_end     = (pos_reg == LAST_POS);
    assign missing_m1 = missing_reg - POS_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg <= spr_pkg::SYNC_BYTE_RESET;
            seed_reg <= spr_pkg::CHECKSUM_SEED_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                spr_pkg::CFG_SYNC_BYTE:     sync_reg <= cfg_data;
                spr_pkg::CFG_CHECKSUM_SEED: seed_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    always_comb
    begin
        if (pos_reg == '0)
        begin
            if (data_byte == sync_reg)
            begin
                cur_mode = spr_pkg::MODE_FULL;
            end
            else if (awaiting_reg && (missing_reg != '0))
            begin
                cur_mode = spr_pkg::MODE_COMPLETE;
            end
            else
            begin
                cur_mode = spr_pkg::MODE_SEARCH;
            end
        end
        else
        begin
            cur_mode = mode_reg;
        end
    end

    always_comb
    begin
        pos_next      = pos_reg;
        mode_next     = mode_reg;
        found_next    = found_reg;
        offset_next   = offset_reg;
        awaiting_next = awaiting_reg;
        missing_next  = missing_reg;
        acc_next      = acc_reg;
        tail_next     = tail_reg;
        prefix_next   = prefix_reg;
        wr_en         = 1'b0;
        wr_addr       = pos_reg;
        cmd           = '0;
        base          = (pos_reg == '0) ? prefix_reg : acc_reg;
        hit           = 1'b0;
        keep          = 1'b0;
        pass          = 1'b0;

        if (take)
        begin
            mode_next = cur_mode;
            pos_next  = is_end ? '0 : pos_reg + POS_W'(1);

            case (cur_mode)
                spr_pkg::MODE_FULL:
                begin
                    wr_en    = 1'b1;
                    wr_addr  = pos_reg;
                    acc_next = ((pos_reg == '0) ? 8'd0 : acc_reg) + data_byte;
                    if (is_end)
                    begin
                        pass          = ((seed_reg - acc_reg) == data_byte);
                        awaiting_next = 1'b0;
                    end
                end
                spr_pkg::MODE_COMPLETE:
                begin
                    if (pos_reg < missing_reg)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = pos_reg + LAST_POS - missing_m1;
                    end
                    if (pos_reg < missing_m1)
                    begin
                        acc_next = base + data_byte;
                    end
                    else if (pos_reg == missing_m1)
                    begin
                        acc_next  = base;
                        tail_next = data_byte;
                    end
                    if (is_end)
                    begin
                        pass = ((seed_reg - acc_reg) == tail_reg);
                        if (pass)
                        begin
                            awaiting_next = 1'b0;
                        end
                        missing_next = '0;
                    end
                end
                default:
                begin
                    hit  = (pos_reg != '0) && !found_reg && (data_byte == sync_reg);
                    keep = ((pos_reg != '0) && found_reg) || hit;
                    found_next = keep;
                    if (hit)
                    begin
                        offset_next = pos_reg;
                        acc_next    = data_byte;
                    end
                    else
                    begin
                        acc_next = acc_reg + data_byte;
                    end
                    if (keep)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = hit ? '0 : pos_reg - offset_reg;
                    end
                    if (is_end && keep)
                    begin
                        missing_next  = hit ? pos_reg : offset_reg;
                        awaiting_next = 1'b1;
                        prefix_next   = acc_next;
                    end
                end
            endcase

            if (is_end)
            begin
                cmd.stream = pass;
                cmd.fail   = !pass;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            mode_reg     <= spr_pkg::MODE_SEARCH;
            found_reg    <= 1'b0;
            offset_reg   <= '0;
            awaiting_reg <= 1'b0;
            missing_reg  <= '0;
        end
        else
        begin
            pos_reg      <= pos_next;
            mode_reg     <= mode_next;
            found_reg    <= found_next;
            offset_reg   <= offset_next;
            awaiting_reg <= awaiting_next;
            missing_reg  <= missing_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        tail_reg   <= tail_next;
        prefix_reg <= prefix_next;
    end

    spr_store #(
        .DEPTH  (PACKET_BYTES),
        .ADDR_W (POS_W)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (data_byte),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .packet_ok (packet_ok),
        .last      (last)
    );

endmodule

`default_nettype wire

@@ src/spr_store.sv @@
// spr_store: packet byte memory, read sequencer and result output register
// depends on spr_pkg
`default_nettype none

module spr_store #(
    parameter int unsigned DEPTH = 29,
    parameter int unsigned ADDR_W = 5
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_W-1:0]    wr_addr,
    input  wire logic [7:0]           wr_data,
    input  wire spr_pkg::store_cmd_t  cmd,
    output spr_pkg::store_status_t    status,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [7:0]                out_byte,
    output logic                      packet_ok,
    output logic                      last
);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    logic [7:0] ram [DEPTH];

    logic              active_reg, active_next;
    logic [ADDR_W-1:0] rd_addr_reg, rd_addr_next;
    logic              pend_reg, pend_next;
    logic              pend_last_reg, pend_last_next;
    logic [7:0]        rd_data_reg;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_byte_reg, out_byte_next;
    logic              packet_ok_reg, packet_ok_next;
    logic              last_reg, last_next;

    logic move;
    logic issue;

    assign move  = pend_reg && (!out_valid_reg || !out_stall);
    assign issue = active_reg && (!pend_reg || move);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ram[wr_addr] <= wr_data;
        end
        if (issue)
        begin
            rd_data_reg <= ram[rd_addr_reg];
        end
    end

    always_comb
    begin
        active_next    = active_reg;
        rd_addr_next   = rd_addr_reg;
        pend_next      = pend_reg;
        pend_last_next = pend_last_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        packet_ok_next = packet_ok_reg;
        last_next      = last_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (move)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = rd_data_reg;
            packet_ok_next = 1'b1;
            last_next      = pend_last_reg;
            pend_next      = 1'b0;
        end
        else if (cmd.fail)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = 8'd0;
            packet_ok_next = 1'b0;
            last_next      = 1'b1;
        end

        if (issue)
        begin
            pend_next      = 1'b1;
            pend_last_next = (rd_addr_reg == LAST_ADDR);
            rd_addr_next   = rd_addr_reg + ADDR_W'(1);
            if (rd_addr_reg == LAST_ADDR)
            begin
                active_next = 1'b0;
            end
        end

        if (cmd.stream)
        begin
            active_next  = 1'b1;
            rd_addr_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            rd_addr_reg   <= '0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            rd_addr_reg   <= rd_addr_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg  <= out_byte_next;
        packet_ok_reg <= packet_ok_next;
        last_reg      <= last_next;
    end

    assign status.busy = active_reg || pend_reg;
    assign status.full = out_valid_reg;
    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign packet_ok   = packet_ok_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire

@@ src/spr_checker.sv @@
// spr_checker: port-level assertions for split_packet_reassembler
// bound to the top level below; sees only its ports
`default_nettype none

module spr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [7:0]  out_byte,
    input wire logic        packet_ok,
    input wire logic        last,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready
);

    // stalled item stays presented
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output item dropped while stalled");

    // a fail result is a single zero item closing the run
    a_fail_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !packet_ok |-> last && (out_byte == 8'd0))
        else $error("fail item malformed");

    // no new byte taken while a packet is mid stream
    a_no_input_mid_stream: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && packet_ok && !last |-> !(in_valid && !in_stall))
        else $error("input accepted during packet stream");

    // packet bytes follow back to back once taken
    a_stream_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && packet_ok && !last |=> out_valid && packet_ok)
        else $error("gap inside packet stream");

    // config port never pushes back
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write refused");

endmodule

bind split_packet_reassembler spr_checker u_spr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .packet_ok (packet_ok),
    .last      (last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

`default_nettype wire
